FILE: hw/rtl/fwm_pkg.sv
// ----------------------------------------------------------------------------
// fwm_pkg
// Shared constants and types of the file specification wildcard matcher.
// ----------------------------------------------------------------------------
package fwm_pkg;

  localparam int PATTERN_CHARS_DEFAULT = 32;
  localparam int PATTERN_CHARS_MAX     = 32;

  localparam int CHAR_W        = 8;
  localparam int LENGTH_W      = 6;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int WORD_CHARS    = CFG_DATA_W / CHAR_W;
  localparam int PATTERN_WORDS = PATTERN_CHARS_MAX / WORD_CHARS;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD0  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

  // special characters
  localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;

  // per-character control broadcast to every cell
  typedef struct packed {
    logic step;     // advance the position set by one text character
    logic restart;  // end of specification, back to the start position
  } fwm_cell_ctl_t;

endpackage

FILE: hw/rtl/fwm_cell.sv
// ----------------------------------------------------------------------------
// fwm_cell
// One pattern position: holds its active bit, passes star closure and
// character advance on to the next position.
// ----------------------------------------------------------------------------
module fwm_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fwm_pkg::fwm_cell_ctl_t      ctl,
  input  logic [fwm_pkg::CHAR_W-1:0]  text_char,
  input  logic [fwm_pkg::CHAR_W-1:0]  pat_char,
  input  logic                        enable,
  input  logic                        closure_in,
  input  logic                        fwd_in,
  output logic                        active,
  output logic                        closure_out,
  output logic                        fwd_out
);

  logic closed;
  logic is_star;
  logic hit;
  logic active_next;

  assign closed      = active | closure_in;
  assign is_star     = (pat_char == fwm_pkg::CH_STAR);
  assign hit         = closed & enable;
  assign closure_out = hit & is_star;
  assign fwd_out     = hit & ~is_star &
                       ((pat_char == fwm_pkg::CH_QUESTION) || (pat_char == text_char));
  // a star keeps itself alive, anything else arrives from the left neighbor
  assign active_next = closure_out | fwd_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= IS_HEAD;
    end else if (ctl.restart) begin
      active <= IS_HEAD;
    end else if (ctl.step) begin
      active <= active_next;
    end
  end

endmodule

FILE: hw/rtl/filespec_wildcard_matcher_core.sv
// ----------------------------------------------------------------------------
// filespec_wildcard_matcher_core
// Matches a streamed NAME.EXT;VERSION specification against a wildcard
// pattern, one character per cycle while in_ready is high, using a row of position cells.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------
//  input    | in        | in_valid/in_ready  | text_char, text_last
//  output   | out       | out_valid/out_ready| matched
//  config   | in        | cfg_write          | cfg_index, cfg_data
//
//  one character is taken every cycle while in_ready is high; the cell row updates
//  the position set in the same cycle through a ripple of star closure across the cells
//  the result appears in the output register in the cycle after the last
//  character is taken and is held until taken
//  in_ready drops only while a result waits and out_ready is low
//  synchronous reset clears the pattern and the length and returns the position set to the start
//
module filespec_wildcard_matcher_core #(
  parameter int PATTERN_CHARS = fwm_pkg::PATTERN_CHARS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fwm_pkg::CHAR_W-1:0]       text_char,
  input  logic                             text_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             matched,
  input  logic                             cfg_write,
  input  logic [fwm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fwm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NW = $clog2(PATTERN_CHARS + 1);

  logic [fwm_pkg::CHAR_W-1:0]   pat [PATTERN_CHARS];
  logic [fwm_pkg::LENGTH_W-1:0] pat_length;
  logic [NW-1:0]                n;
  logic [PATTERN_CHARS-1:0]     en;
  logic [PATTERN_CHARS-1:0]     semi_hit;
  logic                         has_semi;
  logic                         past_mark;
  logic                         accept;
  logic                         cut;
  fwm_pkg::fwm_cell_ctl_t       ctl;

  logic [PATTERN_CHARS:0]       act;
  logic                         act_end;
  logic [PATTERN_CHARS:0]       closure_c;
  logic [PATTERN_CHARS:0]       fwd_c;
  logic                         result;

  // pattern storage
  for (genvar k = 0; k < PATTERN_CHARS; k++) begin : g_pat
    localparam int W = k / fwm_pkg::WORD_CHARS;
    localparam int B = k % fwm_pkg::WORD_CHARS;
    always_ff @(posedge clk) begin
      if (rst) begin
        pat[k] <= '0;
      end else if (cfg_write &&
                   cfg_index == fwm_pkg::CFG_INDEX_W'(fwm_pkg::REG_PATTERN_WORD0 + W)) begin
        pat[k] <= cfg_data[B*fwm_pkg::CHAR_W +: fwm_pkg::CHAR_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_length <= '0;
    end else if (cfg_write && cfg_index == fwm_pkg::REG_PATTERN_LENGTH) begin
      pat_length <= cfg_data[fwm_pkg::LENGTH_W-1:0];
    end
  end

  // length clamped to the cell count
  assign n = (pat_length > fwm_pkg::LENGTH_W'(PATTERN_CHARS)) ? NW'(PATTERN_CHARS)
                                                               : pat_length[NW-1:0];

  for (genvar k = 0; k < PATTERN_CHARS; k++) begin : g_en
    assign en[k]       = (NW'(k) < n);
    assign semi_hit[k] = en[k] && (pat[k] == fwm_pkg::CH_SEMI);
  end
  assign has_semi = |semi_hit;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;
  // version part is skipped when the pattern itself has no semicolon
  assign cut      = (text_char == fwm_pkg::CH_SEMI) && !has_semi;

  assign ctl.step    = accept && !past_mark && !cut;
  assign ctl.restart = accept && text_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      past_mark <= 1'b0;
    end else if (accept) begin
      if (text_last) begin
        past_mark <= 1'b0;
      end else if (!past_mark && cut) begin
        past_mark <= 1'b1;
      end
    end
  end

  // row of position cells
  assign closure_c[0] = 1'b0;
  assign fwd_c[0]     = 1'b0;

  for (genvar k = 0; k < PATTERN_CHARS; k++) begin : g_cell
    fwm_cell #(
      .IS_HEAD (k == 0)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .text_char   (text_char),
      .pat_char    (pat[k]),
      .enable      (en[k]),
      .closure_in  (closure_c[k]),
      .fwd_in      (fwd_c[k]),
      .active      (act[k]),
      .closure_out (closure_c[k+1]),
      .fwd_out     (fwd_c[k+1])
    );
  end

  // end position past the last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      act_end <= 1'b0;
    end else if (ctl.restart) begin
      act_end <= 1'b0;
    end else if (ctl.step) begin
      act_end <= fwd_c[PATTERN_CHARS];
    end
  end
  assign act[PATTERN_CHARS] = act_end;

  // result is taken from the position set before this character's update
  // only when the last character does not step the set; otherwise from after
  // the update, so it is formed from the next set combinationally
  logic [PATTERN_CHARS:0] act_after;
  logic [PATTERN_CHARS:0] closed_after;

  always_comb begin
    act_after = act;
    if (ctl.step) begin
      for (int k = 0; k < PATTERN_CHARS; k++) begin
        act_after[k] = closure_c[k+1] | fwd_c[k];
      end
      act_after[PATTERN_CHARS] = fwd_c[PATTERN_CHARS];
    end
  end

  // second closure pass over the updated set for the final verdict
  always_comb begin
    closed_after[0] = act_after[0];
    for (int k = 1; k <= PATTERN_CHARS; k++) begin
      closed_after[k] = act_after[k] |
                        (closed_after[k-1] & en[k-1] & (pat[k-1] == fwm_pkg::CH_STAR));
    end
  end

  assign result = (n == '0) ? 1'b1 : closed_after[n];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && text_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text_last) begin
      matched <= result;
    end
  end

  // every specification end produces a result
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && text_last |=> out_valid)
    else $error("no result after last character");

  // position set returns to the start after a result
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && text_last |=> (act == (PATTERN_CHARS+1)'(1)) && !past_mark)
    else $error("position set not restarted");

  // empty pattern matches everything
  a_empty_pattern: assert property (@(posedge clk) disable iff (rst)
    accept && text_last && (n == '0) |=> matched)
    else $error("empty pattern did not match");

  // the version part leaves the position set untouched
  a_version_frozen: assert property (@(posedge clk) disable iff (rst)
    accept && past_mark && !text_last |=> $stable(act))
    else $error("position set moved past the version mark");

endmodule
